// File: hdl/cobsdf_pkg.sv
`timescale 1ns / 1ps

package cobsdf_pkg;

    localparam logic [7:0] DELIM_BYTE      = 8'h00;
    localparam logic [7:0] FULL_GROUP_CODE = 8'hFF;
    localparam logic [7:0] CRC_POLY        = 8'h07;
    localparam logic [7:0] MAX_FRAME_RESET = 8'd255;
    localparam logic [7:0] DECODED_MAX     = 8'd255;
    localparam int         QUEUE_DEPTH_DEF = 2;

    typedef enum logic {
        ITEM_DATA,
        ITEM_END
    } item_kind_t;

    typedef enum logic [2:0] {
        STATUS_GOOD      = 3'd0,
        STATUS_CRC       = 3'd1,
        STATUS_TRUNCATED = 3'd2,
        STATUS_OVERFLOW  = 3'd3,
        STATUS_EMPTY     = 3'd4
    } frame_status_t;

    typedef struct packed {
        item_kind_t kind;
        logic [7:0] data;
        logic       overflow;
        logic       truncated;
    } qitem_t;

    typedef struct packed {
        logic   valid;
        qitem_t item;
    } qpush_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// File: hdl/cobsdf_front.sv
`timescale 1ns / 1ps

module cobsdf_front
    import cobsdf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_line_byte,
    input  logic       queue_full,
    output qpush_t     push
);

    logic [7:0] max_frame_reg;
    logic [7:0] group_left_reg, group_left_next;
    logic       zero_pending_reg, zero_pending_next;
    logic [7:0] raw_count_reg, raw_count_next;
    logic       overflow_reg, overflow_next;
    logic       accept;

    assign s_ready = !queue_full;
    assign accept  = s_valid && !queue_full;

    always_comb begin
        group_left_next   = group_left_reg;
        zero_pending_next = zero_pending_reg;
        raw_count_next    = raw_count_reg;
        overflow_next     = overflow_reg;
        push.valid          = 1'b0;
        push.item.kind      = ITEM_DATA;
        push.item.data      = s_line_byte;
        push.item.overflow  = overflow_reg;
        push.item.truncated = (group_left_reg != 8'd0);
        if (accept) begin
            if (s_line_byte == DELIM_BYTE) begin
                push.valid        = 1'b1;
                push.item.kind    = ITEM_END;
                group_left_next   = 8'd0;
                zero_pending_next = 1'b0;
                raw_count_next    = 8'd0;
                overflow_next     = 1'b0;
            end else if (raw_count_reg >= max_frame_reg) begin
                overflow_next = 1'b1;
            end else begin
                raw_count_next = raw_count_reg + 8'd1;
                if (group_left_reg != 8'd0) begin
                    group_left_next = group_left_reg - 8'd1;
                    push.valid      = 1'b1;
                end else begin
                    group_left_next   = s_line_byte - 8'd1;
                    zero_pending_next = (s_line_byte != FULL_GROUP_CODE);
                    push.valid        = zero_pending_reg;
                    push.item.data    = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_reg    <= MAX_FRAME_RESET;
            group_left_reg   <= 8'd0;
            zero_pending_reg <= 1'b0;
            raw_count_reg    <= 8'd0;
            overflow_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_frame_reg <= cfg_wdata;
            end
            group_left_reg   <= group_left_next;
            zero_pending_reg <= zero_pending_next;
            raw_count_reg    <= raw_count_next;
            overflow_reg     <= overflow_next;
        end
    end

endmodule

// File: hdl/cobsdf_queue.sv
`timescale 1ns / 1ps

module cobsdf_queue
    import cobsdf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  qpush_t push,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output qitem_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    qitem_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/cobsdf_back.sv
`timescale 1ns / 1ps

module cobsdf_back
    import cobsdf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       empty,
    input  qitem_t     head,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic [7:0] m_payload_index,
    output logic       m_is_end,
    output logic [2:0] m_frame_status
);

    logic          valid_reg, valid_next;
    logic [7:0]    byte_reg, byte_next;
    logic [7:0]    index_reg, index_next;
    logic          end_reg, end_next;
    frame_status_t status_reg, status_next;
    logic [7:0]    dcount_reg, dcount_next;
    logic [7:0]    crc_reg, crc_next;
    logic [7:0]    expect_reg, expect_next;
    logic          out_free;

    assign out_free = !valid_reg || m_ready;
    assign pop      = !empty && out_free;

    always_comb begin
        valid_next  = valid_reg && !m_ready;
        byte_next   = byte_reg;
        index_next  = index_reg;
        end_next    = end_reg;
        status_next = status_reg;
        dcount_next = dcount_reg;
        crc_next    = crc_reg;
        expect_next = expect_reg;
        if (pop) begin
            if (head.kind == ITEM_END) begin
                valid_next = 1'b1;
                byte_next  = 8'd0;
                index_next = (dcount_reg != 8'd0) ? dcount_reg - 8'd1 : 8'd0;
                end_next   = 1'b1;
                if (head.overflow) begin
                    status_next = STATUS_OVERFLOW;
                end else if (head.truncated) begin
                    status_next = STATUS_TRUNCATED;
                end else if (dcount_reg == 8'd0) begin
                    status_next = STATUS_EMPTY;
                end else if (crc_reg != expect_reg) begin
                    status_next = STATUS_CRC;
                end else begin
                    status_next = STATUS_GOOD;
                end
                dcount_next = 8'd0;
                crc_next    = 8'd0;
                expect_next = 8'd0;
            end else if (dcount_reg == 8'd0) begin
                expect_next = head.data;
                dcount_next = 8'd1;
            end else begin
                valid_next  = 1'b1;
                byte_next   = head.data;
                index_next  = dcount_reg - 8'd1;
                end_next    = 1'b0;
                status_next = STATUS_GOOD;
                crc_next    = crc8_step(crc_reg, head.data);
                if (dcount_reg != DECODED_MAX) begin
                    dcount_next = dcount_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            dcount_reg <= 8'd0;
            crc_reg    <= 8'd0;
            expect_reg <= 8'd0;
        end else begin
            valid_reg  <= valid_next;
            dcount_reg <= dcount_next;
            crc_reg    <= crc_next;
            expect_reg <= expect_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        index_reg  <= index_next;
        end_reg    <= end_next;
        status_reg <= status_next;
    end

    assign m_valid         = valid_reg;
    assign m_payload_byte  = byte_reg;
    assign m_payload_index = index_reg;
    assign m_is_end        = end_reg;
    assign m_frame_status  = status_reg;

endmodule

// File: hdl/cobs_deframer_crc8_check_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                                     Transaction
// line in   in         s_valid s_ready s_line_byte               one encoded byte
// result    out        m_valid m_ready m_payload_byte            one payload byte
//                      m_payload_index m_is_end m_frame_status   or end-of-frame verdict
// config    in         cfg_we cfg_wdata                          max encoded bytes per frame
//
// One encoded byte per cycle while s_ready is high; each takes at most one group update.
// Payload bytes take one CRC-8 step; a result passes the queue slot, then the back register.
// Reset is synchronous, active low; no clearing pass, the block is ready next cycle.
// The queue between front and back absorbs result-side stalls; s_ready drops when it fills.

module cobs_deframer_crc8_check_unit
    import cobsdf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_line_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic [7:0] m_payload_index,
    output logic       m_is_end,
    output logic [2:0] m_frame_status
);

    qpush_t push;
    qitem_t head;
    logic   queue_full;
    logic   queue_empty;
    logic   pop;

    cobsdf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_line_byte (s_line_byte),
        .queue_full  (queue_full),
        .push        (push)
    );

    cobsdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (queue_full),
        .pop     (pop),
        .empty   (queue_empty),
        .head    (head)
    );

    cobsdf_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .empty           (queue_empty),
        .head            (head),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_is_end        (m_is_end),
        .m_frame_status  (m_frame_status)
    );

endmodule
